// ===== sv/utf8_to_utf16_decoder_assert.svh =====
// Assertion macros shared by the UTF-8 to UTF-16 decoder modules.
`ifndef UTF8_TO_UTF16_DECODER_ASSERT_SVH
`define UTF8_TO_UTF16_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define U8U16_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
    else $error("u8u16 assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define U8U16_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
    else $error("u8u16 assertion failed");

`endif

// ===== sv/u8u16_pkg.sv =====
// Package: widths, byte class constants, result type and surrogate split for the decoder.
`default_nettype none
package u8u16_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned UNIT_W = 16;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned DUE_W  = 2;
  localparam int unsigned CNT_W  = 2;

  localparam logic [BYTE_W-1:0] LEAD4_MIN  = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_MIN  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_MIN  = 8'hC0;
  localparam logic [BYTE_W-1:0] ASCII_END  = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'h07;
  localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'h0F;
  localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'h1F;
  localparam logic [BYTE_W-1:0] CONT_MASK  = 8'h3F;
  localparam logic [BYTE_W-1:0] CONT_SEL   = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_TAG   = 8'h80;

  localparam logic [CP_W-1:0]   SUPP_BASE  = 21'h10000;
  localparam logic [UNIT_W-1:0] HI_BASE    = 16'hD800;
  localparam logic [UNIT_W-1:0] LO_BASE    = 16'hDC00;
  localparam logic [UNIT_W-1:0] LO_MASK    = 16'h03FF;

  localparam logic [DUE_W-1:0]  DUE_NONE   = 2'd0;
  localparam logic [DUE_W-1:0]  DUE_ONE    = 2'd1;
  localparam logic [DUE_W-1:0]  DUE_TWO    = 2'd2;
  localparam logic [DUE_W-1:0]  DUE_THREE  = 2'd3;

  typedef struct packed {
    logic [CNT_W-1:0]  cnt;
    logic [UNIT_W-1:0] unit0;
    logic [UNIT_W-1:0] unit1;
  } u8u16_emit_t;

  function automatic u8u16_emit_t emit_cp(input logic [CP_W-1:0] cp);
    u8u16_emit_t e;
    logic [CP_W-1:0] t;
    t = cp - SUPP_BASE;
    if (cp < SUPP_BASE) begin
      e.cnt   = 2'd1;
      e.unit0 = cp[UNIT_W-1:0];
      e.unit1 = '0;
    end else begin
      e.cnt   = 2'd2;
      e.unit0 = HI_BASE + {5'd0, t[CP_W-1:10]};
      e.unit1 = LO_BASE + (t[UNIT_W-1:0] & LO_MASK);
    end
    return e;
  endfunction

endpackage
`default_nettype wire

// ===== sv/u8u16_step.sv =====
// Sequence decoder: code point accumulator, continuation count and unit generation per byte.
`default_nettype none
`include "utf8_to_utf16_decoder_assert.svh"
module u8u16_step
  import u8u16_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [BYTE_W-1:0] byte_val,
  input  wire logic              byte_last,
  input  wire logic              fire,
  output u8u16_emit_t            res
);

  logic [CP_W-1:0]  cp_r,  cp_nxt;
  logic [DUE_W-1:0] due_r, due_nxt;

  always_comb begin
    logic [CP_W-1:0]  lead_cp;
    logic [DUE_W-1:0] lead_due;
    logic [CP_W-1:0]  acc;
    logic [DUE_W-1:0] due_dec;
    res      = '0;
    cp_nxt   = cp_r;
    due_nxt  = due_r;
    lead_cp  = '0;
    lead_due = DUE_NONE;
    acc      = {cp_r[CP_W-7:0], byte_val[5:0]};
    due_dec  = due_r - DUE_ONE;
    if (due_r == DUE_NONE) begin
      priority if (byte_val < ASCII_END) begin
        res.cnt   = 2'd1;
        res.unit0 = {{(UNIT_W-BYTE_W){1'b0}}, byte_val};
      end else if (byte_val < LEAD2_MIN) begin
        res = '0;
      end else begin
        priority if (byte_val >= LEAD4_MIN) begin
          lead_cp  = CP_W'(byte_val & LEAD4_MASK);
          lead_due = DUE_THREE;
        end else if (byte_val >= LEAD3_MIN) begin
          lead_cp  = CP_W'(byte_val & LEAD3_MASK);
          lead_due = DUE_TWO;
        end else begin
          lead_cp  = CP_W'(byte_val & LEAD2_MASK);
          lead_due = DUE_ONE;
        end
        if (byte_last) begin
          res     = emit_cp(lead_cp);
          cp_nxt  = '0;
          due_nxt = DUE_NONE;
        end else begin
          cp_nxt  = lead_cp;
          due_nxt = lead_due;
        end
      end
    end else if ((byte_val & CONT_SEL) != CONT_TAG) begin
      res     = emit_cp(cp_r);
      cp_nxt  = '0;
      due_nxt = DUE_NONE;
    end else if (due_dec == DUE_NONE || byte_last) begin
      res     = emit_cp(acc);
      cp_nxt  = '0;
      due_nxt = DUE_NONE;
    end else begin
      cp_nxt  = acc;
      due_nxt = due_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cp_r  <= '0;
      due_r <= DUE_NONE;
    end else if (fire) begin
      cp_r  <= cp_nxt;
      due_r <= due_nxt;
    end
  end

  `U8U16_ASSERT_IMPL(a_idle_clear, clk, rst_n, due_r == DUE_NONE, cp_r == '0)
  `U8U16_ASSERT_NEXT(a_last_idle, clk, rst_n, fire && byte_last, due_r == DUE_NONE)
  `U8U16_ASSERT_NEXT(a_break_idle, clk, rst_n, fire && due_r != DUE_NONE && (byte_val & CONT_SEL) != CONT_TAG, due_r == DUE_NONE)

endmodule
`default_nettype wire

// ===== sv/utf8_to_utf16_decoder.sv =====
// Top level: input register, sequence decoder and two-entry result queue.
`default_nettype none
`include "utf8_to_utf16_decoder_assert.svh"
// Streaming UTF-8 to UTF-16 decoder. One byte is taken per clock while in_ready
// is high; each byte is registered, decoded in the following cycle and yields
// zero, one or two 16-bit units into a two-entry result queue, whose head drives
// the output. Input runs at one byte per clock as long as the output
// drains; a surrogate pair puts two units into the queue, so a string of
// four-byte sequences sustains one byte per clock while the queue holds room.
// The input stalls only when the queue cannot hold the units of the decoded byte.
module utf8_to_utf16_decoder
  import u8u16_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [BYTE_W-1:0] in_byte_req,
  input  wire logic              in_last,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [UNIT_W-1:0]      out_unit,
  output logic                   out_run_last
);

  logic              in_v_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              in_last_r;

  logic              q0_v_r, q0_v_nxt, q1_v_r, q1_v_nxt;
  logic [UNIT_W-1:0] q0_unit_r, q0_unit_nxt, q1_unit_r, q1_unit_nxt;
  logic              q0_last_r, q0_last_nxt, q1_last_r, q1_last_nxt;

  u8u16_emit_t       res;
  logic              pop;
  logic              dec_fire;
  logic [CNT_W-1:0]  kept_cnt;
  logic [CNT_W-1:0]  room;
  logic [CNT_W-1:0]  push;
  logic [CNT_W-1:0]  total;
  logic [UNIT_W-1:0] kept_unit;
  logic              kept_last;

  u8u16_step u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_val (in_byte_r),
    .byte_last(in_last_r),
    .fire     (dec_fire),
    .res      (res)
  );

  assign pop       = q0_v_r & out_ready;
  assign kept_cnt  = {1'b0, q0_v_r} + {1'b0, q1_v_r} - {1'b0, pop};
  assign room      = 2'd2 - kept_cnt;
  assign dec_fire  = in_v_r && (res.cnt <= room);
  assign push      = dec_fire ? res.cnt : 2'd0;
  assign total     = kept_cnt + push;
  assign kept_unit = pop ? q1_unit_r : q0_unit_r;
  assign kept_last = pop ? q1_last_r : q0_last_r;
  assign in_ready  = !in_v_r || dec_fire;

  assign out_valid    = q0_v_r;
  assign out_unit     = q0_unit_r;
  assign out_run_last = q0_last_r;

  always_comb begin
    q0_v_nxt    = total != 2'd0;
    q1_v_nxt    = total >= 2'd2;
    q0_unit_nxt = q0_unit_r;
    q0_last_nxt = q0_last_r;
    q1_unit_nxt = q1_unit_r;
    q1_last_nxt = q1_last_r;
    unique case (kept_cnt)
      2'd0: begin
        q0_unit_nxt = res.unit0;
        q0_last_nxt = push == 2'd1;
        q1_unit_nxt = res.unit1;
        q1_last_nxt = 1'b1;
      end
      2'd1: begin
        q0_unit_nxt = kept_unit;
        q0_last_nxt = kept_last;
        q1_unit_nxt = res.unit0;
        q1_last_nxt = 1'b1;
      end
      default: begin
        q0_unit_nxt = q0_unit_r;
        q0_last_nxt = q0_last_r;
        q1_unit_nxt = q1_unit_r;
        q1_last_nxt = q1_last_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      q0_v_r <= 1'b0;
      q1_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      q0_v_r <= q0_v_nxt;
      q1_v_r <= q1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_byte_req;
      in_last_r <= in_last;
    end
    q0_unit_r <= q0_unit_nxt;
    q0_last_r <= q0_last_nxt;
    q1_unit_r <= q1_unit_nxt;
    q1_last_r <= q1_last_nxt;
  end

  `U8U16_ASSERT_IMPL(a_queue_order, clk, rst_n, q1_v_r, q0_v_r)
  `U8U16_ASSERT_IMPL(a_pair_whole, clk, rst_n, q0_v_r && !q0_last_r, q1_v_r)
  `U8U16_ASSERT_NEXT(a_pop_shift, clk, rst_n, q1_v_r && pop, q0_v_r && q0_unit_r == $past(q1_unit_r))

endmodule
`default_nettype wire
